### hw/rtl/dgc_pkg.sv
// ----------------------------------------------------------------------------
// dgc_pkg
// Shared types, constants and constant functions for the divergence gain core.
// ----------------------------------------------------------------------------
package dgc_pkg;

  localparam int MAX_TRACE_SAMPLES = 65536;
  localparam int FRAC_BITS         = 16;
  localparam int MANT_SHIFT        = 30;
  localparam int LOG2_1E6_Q16      = 1306235;

  localparam logic [15:0] INTERVAL_RESET = 16'd4000;
  localparam logic [15:0] EXPONENT_RESET = 16'd8192;

  // register indexes on the configuration port
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_EXPONENT = 2'd2;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [15:0]        sample_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] scaled_sample;
    logic               saturated;
  } out_item_t;

  // per-item data that rides along the pipeline
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic        zero;
    logic        pass;
    logic        mode;
    logic [15:0] expo;
  } side_t;

  // bitwise integer square root, used at elaboration only
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q30 root constant floor(2^(2^-i) * 2^30), i from 1
  function automatic logic [30:0] root_const(int i);
    logic [63:0] c;
    c = isqrt64(64'd2 << 60);
    for (int j = 1; j < i; j++) begin
      c = isqrt64(c << MANT_SHIFT);
    end
    return c[30:0];
  endfunction

endpackage

### hw/rtl/dgc_log2.sv
// ----------------------------------------------------------------------------
// dgc_log2
// Pipelined log2 of a 32-bit product: leading-one search, normalize, then one
// squaring stage per fractional bit.
// ----------------------------------------------------------------------------
module dgc_log2 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        p,
  input  dgc_pkg::side_t     in_side,
  output logic               out_valid,
  output logic [4:0]         lg_int,
  output logic [15:0]        lg_frac,
  output dgc_pkg::side_t     out_side
);
  import dgc_pkg::*;

  logic        valid_a;
  logic [4:0]  n_a;
  logic [31:0] p_a;
  side_t       side_a;
  logic [4:0]  n_find;

  logic        valid_q [0:FRAC_BITS];
  logic [30:0] m_q     [0:FRAC_BITS];
  logic [15:0] frac_q  [0:FRAC_BITS];
  logic [4:0]  n_q     [0:FRAC_BITS];
  side_t       side_q  [0:FRAC_BITS];
  logic [61:0] norm;

  // find the leading one
  always_comb begin
    n_find = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (p[i]) n_find = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid_a <= 1'b0;
    else     valid_a <= in_valid;
    n_a    <= n_find;
    p_a    <= p;
    side_a <= in_side;
  end

  // normalize to a Q30 mantissa in [1,2)
  assign norm = {p_a, 30'd0} >> n_a;

  always_ff @(posedge clk) begin
    if (rst) valid_q[0] <= 1'b0;
    else     valid_q[0] <= valid_a;
    m_q[0]    <= norm[30:0];
    frac_q[0] <= 16'd0;
    n_q[0]    <= n_a;
    side_q[0] <= side_a;
  end

  // square, take one fraction bit per stage
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = m_q[s] * m_q[s];
    assign t  = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) valid_q[s+1] <= 1'b0;
      else     valid_q[s+1] <= valid_q[s];
      m_q[s+1]    <= t[31] ? t[31:1] : t[30:0];
      frac_q[s+1] <= {frac_q[s][14:0], t[31]};
      n_q[s+1]    <= n_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign out_valid = valid_q[FRAC_BITS];
  assign lg_int    = n_q[FRAC_BITS];
  assign lg_frac   = frac_q[FRAC_BITS];
  assign out_side  = side_q[FRAC_BITS];

endmodule

### hw/rtl/dgc_exp2.sv
// ----------------------------------------------------------------------------
// dgc_exp2
// Pipelined 2^f for a 16-bit fraction: one conditional root multiply per stage.
// ----------------------------------------------------------------------------
module dgc_exp2 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [11:0] in_k,
  input  logic [15:0]        f,
  input  dgc_pkg::side_t     in_side,
  output logic               out_valid,
  output logic signed [11:0] out_k,
  output logic [30:0]        r,
  output dgc_pkg::side_t     out_side
);
  import dgc_pkg::*;

  logic               valid_q [0:FRAC_BITS];
  logic [30:0]        r_q     [0:FRAC_BITS];
  logic [15:0]        f_q     [0:FRAC_BITS];
  logic signed [11:0] k_q     [0:FRAC_BITS];
  side_t              side_q  [0:FRAC_BITS];

  assign valid_q[0] = in_valid;
  assign r_q[0]     = 31'(64'd1 << MANT_SHIFT);
  assign f_q[0]     = f;
  assign k_q[0]     = in_k;
  assign side_q[0]  = in_side;

  // multiply by the i-th root when its fraction bit is set
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_root
    localparam logic [30:0] ROOT = root_const(s + 1);
    logic [61:0] prod;
    assign prod = r_q[s] * ROOT;

    always_ff @(posedge clk) begin
      if (rst) valid_q[s+1] <= 1'b0;
      else     valid_q[s+1] <= valid_q[s];
      r_q[s+1]    <= f_q[s][FRAC_BITS-1-s] ? prod[60:30] : r_q[s];
      f_q[s+1]    <= f_q[s];
      k_q[s+1]    <= k_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign out_valid = valid_q[FRAC_BITS];
  assign out_k     = k_q[FRAC_BITS];
  assign r         = r_q[FRAC_BITS];
  assign out_side  = side_q[FRAC_BITS];

endmodule

### hw/rtl/dgc_scale.sv
// ----------------------------------------------------------------------------
// dgc_scale
// Multiply the magnitude by 2^f, shift by k-30 with rounding, saturate and
// restore the sign.
// ----------------------------------------------------------------------------
module dgc_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [11:0] k,
  input  logic [30:0]        r,
  input  dgc_pkg::side_t     in_side,
  output logic               out_valid,
  output dgc_pkg::out_item_t out_item
);
  import dgc_pkg::*;

  logic               valid_p;
  logic [62:0]        prod_p;
  logic signed [12:0] sh_p;
  side_t              side_p;

  logic               valid_s;
  logic [63:0]        val_s;
  logic               sat_s;
  side_t              side_s;

  logic [31:0]        lim;
  logic [12:0]        rsh;
  logic [63:0]        val_next;
  logic               sat_next;

  logic [31:0]        lim_s;
  logic [31:0]        res;
  logic               sat_o;

  // multiply magnitude by the fractional gain
  always_ff @(posedge clk) begin
    if (rst) valid_p <= 1'b0;
    else     valid_p <= in_valid;
    prod_p <= 63'(in_side.mag) * 63'(r);
    sh_p   <= 13'(k) - 13'sd30;
    side_p <= in_side;
  end

  // shift left with overflow check, or right with round half away from zero
  assign lim = side_p.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign rsh = 13'(-sh_p);

  always_comb begin
    val_next = 64'd0;
    sat_next = 1'b0;
    if (prod_p == 63'd0) begin
      val_next = 64'd0;
    end else if (sh_p >= 13'sd0) begin
      if (sh_p >= 13'sd34) begin
        sat_next = 1'b1;
      end else begin
        sat_next = 64'(prod_p) > (64'(lim) >> sh_p[5:0]);
        val_next = 64'(prod_p) << sh_p[5:0];
      end
    end else if (rsh >= 13'd63) begin
      val_next = 64'd0;
    end else begin
      val_next = (64'(prod_p) + (64'd1 << (rsh[5:0] - 6'd1))) >> rsh[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid_s <= 1'b0;
    else     valid_s <= valid_p;
    val_s  <= val_next;
    sat_s  <= sat_next;
    side_s <= side_p;
  end

  // clip and restore the sign
  assign lim_s = side_s.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

  always_comb begin
    res   = val_s[31:0];
    sat_o = 1'b0;
    if (side_s.pass) begin
      res = side_s.mag;
    end else if (side_s.zero) begin
      res = 32'd0;
    end else if (sat_s || val_s > 64'(lim_s)) begin
      res   = lim_s;
      sat_o = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= valid_s;
    out_item.scaled_sample <= side_s.neg ? -res : res;
    out_item.saturated     <= sat_o;
  end

endmodule

### hw/rtl/divergence_gain_correction_core.sv
// ----------------------------------------------------------------------------
// divergence_gain_correction_core
// Applies or removes a t^alpha spherical divergence gain on trace samples.
// ----------------------------------------------------------------------------
// A start beat runs through capture, log2, product, split, exp2 and scale to done.
// Throughput: one sample per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 16 squaring stages of log2 and 16 root stages of exp2.
// Reset: synchronous, clears all valid bits and loads register defaults.
module divergence_gain_correction_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dgc_pkg::in_item_t  item,
  output logic               done,
  output dgc_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dgc_pkg::*;

  logic        divide_mode;
  logic [15:0] sample_interval_us;
  logic [15:0] exponent_q12;

  logic        valid_0;
  logic [31:0] p_0;
  side_t       side_0;
  side_t       side_0_z;
  side_t       side_in;
  logic        neg_in;

  logic        lg_valid;
  logic [4:0]  lg_int;
  logic [15:0] lg_frac;
  side_t       lg_side;
  logic signed [21:0] lg;

  logic               valid_m;
  logic signed [38:0] eprod_m;
  side_t              side_m;

  logic signed [38:0] e_sum;
  logic signed [26:0] e_floor;
  logic signed [27:0] e_adj;

  logic               valid_e;
  logic signed [11:0] k_e;
  logic [15:0]        f_e;
  side_t              side_e;

  logic               x_valid;
  logic signed [11:0] x_k;
  logic [30:0]        x_r;
  side_t              x_side;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_mode        <= 1'b0;
      sample_interval_us <= INTERVAL_RESET;
      exponent_q12       <= EXPONENT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:     divide_mode        <= pwdata[0];
        REG_INTERVAL: sample_interval_us <= pwdata[15:0];
        REG_EXPONENT: exponent_q12       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:     prdata = {31'd0, divide_mode};
      REG_INTERVAL: prdata = {16'd0, sample_interval_us};
      REG_EXPONENT: prdata = {16'd0, exponent_q12};
      default:      prdata = 32'd0;
    endcase
  end

  assign busy = 1'b0;

  // capture beat, form time product and magnitude
  assign neg_in       = item.sample[31];
  assign side_in.mag  = neg_in ? 32'(-item.sample) : 32'(item.sample);
  assign side_in.neg  = neg_in;
  assign side_in.pass = 32'(item.sample_index) >= 32'(MAX_TRACE_SAMPLES);
  assign side_in.zero = 1'b0;
  assign side_in.mode = divide_mode;
  assign side_in.expo = exponent_q12;

  always_ff @(posedge clk) begin
    if (rst) valid_0 <= 1'b0;
    else     valid_0 <= start;
    p_0    <= 32'(item.sample_index) * 32'(sample_interval_us);
    side_0 <= side_in;
  end

  always_comb begin
    side_0_z = side_0;
    side_0_z.zero = (p_0 == 32'd0);
  end

  dgc_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_0),
    .p         (p_0),
    .in_side   (side_0_z),
    .out_valid (lg_valid),
    .lg_int    (lg_int),
    .lg_frac   (lg_frac),
    .out_side  (lg_side)
  );

  // log2(t) and alpha product
  assign lg = $signed({1'b0, lg_int, lg_frac}) - 22'(LOG2_1E6_Q16);

  always_ff @(posedge clk) begin
    if (rst) valid_m <= 1'b0;
    else     valid_m <= lg_valid;
    eprod_m <= 39'($signed({1'b0, lg_side.expo})) * 39'(lg);
    side_m  <= lg_side;
  end

  // round to Q16, negate for remove mode, split integer and fraction
  assign e_sum   = eprod_m + 39'sd2048;
  assign e_floor = 27'(e_sum >>> 12);
  assign e_adj   = side_m.mode ? -28'(e_floor) : 28'(e_floor);

  always_ff @(posedge clk) begin
    if (rst) valid_e <= 1'b0;
    else     valid_e <= valid_m;
    k_e    <= e_adj[27:16];
    f_e    <= e_adj[15:0];
    side_e <= side_m;
  end

  dgc_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_e),
    .in_k      (k_e),
    .f         (f_e),
    .in_side   (side_e),
    .out_valid (x_valid),
    .out_k     (x_k),
    .r         (x_r),
    .out_side  (x_side)
  );

  dgc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x_valid),
    .k         (x_k),
    .r         (x_r),
    .in_side   (x_side),
    .out_valid (done),
    .out_item  (result)
  );

endmodule
